// ===== design/assert_macros.svh =====
// Assertion helpers shared by the halftoner modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define SEDH_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
`define SEDH_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define SEDH_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define SEDH_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif

`endif

// ===== design/sedh_pkg.sv =====
`default_nettype none

package sedh_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int PIX_W       = 8;
  localparam int ERR_W       = 10;
  localparam int ACC_W       = ERR_W + 2;
  localparam int SHARE_SHIFT = 4;
  localparam int PROD_W      = ERR_W + SHARE_SHIFT;
  localparam int PIX_MAX     = 255;

  localparam int IMG_W_W    = 11;
  localparam int IMG_H_W    = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [IMG_W_W-1:0] IMG_WIDTH_RST  = 11'd256;
  localparam logic [IMG_H_W-1:0] IMG_HEIGHT_RST = 13'd256;
  localparam logic [PIX_W-1:0]   THRESHOLD_RST  = 8'd128;
  localparam logic [PIX_W-1:0]   PIX_WHITE      = 8'hFF;
  localparam logic [PIX_W-1:0]   PIX_BLACK      = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_THRESHOLD    = 2'd2
  } cfg_reg_t;

  // Position of the pixel held in the input stage.
  typedef struct packed {
    logic first;      // first pixel of its row
    logic row_end;
    logic frame_end;
    logic row0;       // first row of the frame: nothing diffused from above
    logic l2r;        // row runs left to right
  } pos_flags_t;

endpackage

`default_nettype wire

// ===== design/serpentine_error_diffusion_halftone.sv =====
`default_nettype none

// Floyd-Steinberg halftoner for one gray plane delivered in serpentine order
// (row 0 right to left, alternating after that); each plane is one frame.
// One result per accepted pixel, registered from the input stage once the
// result register is free, and a new pixel every cycle sustained while
// result_ready holds: the 7/16 carry into the next pixel closes through one
// add, saturate and threshold compare per cycle, and the single MAX_WIDTH x
// 10-bit line store takes one read and at most one write per pixel.
// The first row of a frame ignores the store, so no clearing pass is needed
// after reset or between frames. Write configuration only with the pipeline
// empty; widths and heights outside 1..MAX are clamped.
module serpentine_error_diffusion_halftone import sedh_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  pixel_in_valid,
  output logic                       pixel_in_ready,
  input  wire logic [PIX_W-1:0]      pixel_in,
  output logic                       result_valid,
  input  wire logic                  result_ready,
  output logic      [PIX_W-1:0]      pixel_out,
  output logic                       row_end,
  output logic                       frame_end
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic             stage_valid, advance, read_en, wr_en;
  logic [PIX_W-1:0] stage_pixel, threshold;
  logic [COL_W-1:0] stage_x, read_x, wr_addr;
  logic [ERR_W-1:0] ram_rdata, wr_data;
  pos_flags_t       stage_pos;

  sedh_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pixel_in_valid (pixel_in_valid),
    .pixel_in_ready (pixel_in_ready),
    .pixel_in       (pixel_in),
    .advance        (advance),
    .stage_valid    (stage_valid),
    .stage_pixel    (stage_pixel),
    .stage_x        (stage_x),
    .stage_pos      (stage_pos),
    .read_en        (read_en),
    .read_x         (read_x),
    .threshold      (threshold)
  );

  sedh_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (read_en),
    .raddr (read_x),
    .rdata (ram_rdata)
  );

  sedh_diffuse #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_diffuse (
    .clk          (clk),
    .rst          (rst),
    .stage_valid  (stage_valid),
    .stage_pixel  (stage_pixel),
    .stage_x      (stage_x),
    .stage_pos    (stage_pos),
    .ram_rdata    (ram_rdata),
    .threshold    (threshold),
    .fire         (advance),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .pixel_out    (pixel_out),
    .row_end      (row_end),
    .frame_end    (frame_end)
  );

endmodule

`default_nettype wire

// ===== design/sedh_line_store.sv =====
`default_nettype none

module sedh_line_store import sedh_pkg::*; #(
  parameter int DEPTH = DEF_MAX_WIDTH
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [ERR_W-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [ERR_W-1:0]         rdata
);

  logic [ERR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/sedh_scan.sv =====
`default_nettype none

`include "assert_macros.svh"

module sedh_scan import sedh_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int COL_W = $clog2(MAX_WIDTH),
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  pixel_in_valid,
  output logic                       pixel_in_ready,
  input  wire logic [PIX_W-1:0]      pixel_in,
  input  wire logic                  advance,
  output logic                       stage_valid,
  output logic      [PIX_W-1:0]      stage_pixel,
  output logic      [COL_W-1:0]      stage_x,
  output pos_flags_t                 stage_pos,
  output logic                       read_en,
  output logic      [COL_W-1:0]      read_x,
  output logic      [PIX_W-1:0]      threshold
);

  logic [IMG_W_W-1:0] image_width;
  logic [IMG_H_W-1:0] image_height;
  logic [COL_W-1:0]   column_count;
  logic [ROW_W-1:0]   row_count;

  logic [COL_W-1:0] wlast, col;
  logic [ROW_W-1:0] hlast, row;
  logic             accept, l2r, row_end_pos, frame_end_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMG_WIDTH_RST;
      image_height <= IMG_HEIGHT_RST;
      threshold    <= THRESHOLD_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[IMG_W_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[IMG_H_W-1:0];
        CFG_THRESHOLD:    threshold    <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Last column and last row, with out-of-range settings clamped.
  always_comb begin
    if (image_width == '0) begin
      wlast = '0;
    end else if (32'(image_width) > MAX_WIDTH) begin
      wlast = COL_W'(MAX_WIDTH - 1);
    end else begin
      wlast = COL_W'(image_width - IMG_W_W'(1));
    end
    if (image_height == '0) begin
      hlast = '0;
    end else if (32'(image_height) > MAX_HEIGHT) begin
      hlast = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      hlast = ROW_W'(image_height - IMG_H_W'(1));
    end
  end

  always_comb begin
    col           = (column_count > wlast) ? wlast : column_count;
    row           = (row_count > hlast) ? hlast : row_count;
    l2r           = row[0];
    read_x        = l2r ? col : (wlast - col);
    row_end_pos   = (col == wlast);
    frame_end_pos = row_end_pos && (row == hlast);
  end

  assign pixel_in_ready = !stage_valid || advance;
  assign accept         = pixel_in_valid && pixel_in_ready;
  assign read_en        = accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (frame_end_pos) begin
        column_count <= '0;
        row_count    <= '0;
      end else if (row_end_pos) begin
        column_count <= '0;
        row_count    <= row + ROW_W'(1);
      end else begin
        column_count <= col + COL_W'(1);
        row_count    <= row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_pixel         <= pixel_in;
      stage_x             <= read_x;
      stage_pos.first     <= (col == '0);
      stage_pos.row_end   <= row_end_pos;
      stage_pos.frame_end <= frame_end_pos;
      stage_pos.row0      <= (row == '0);
      stage_pos.l2r       <= l2r;
    end
  end

  `SEDH_ASSERT(a_ready_when_empty, clk, rst, !stage_valid |-> pixel_in_ready,
               "input stage empty but not ready")
  `SEDH_ASSERT(a_row_wrap, clk, rst, (accept && row_end_pos) |=> (column_count == '0),
               "column counter did not wrap at row end")
  `SEDH_ASSERT(a_no_advance_empty, clk, rst, advance |-> stage_valid,
               "advance with empty input stage")

endmodule

`default_nettype wire

// ===== design/sedh_diffuse.sv =====
`default_nettype none

`include "assert_macros.svh"

module sedh_diffuse import sedh_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              stage_valid,
  input  wire logic [PIX_W-1:0]  stage_pixel,
  input  wire logic [COL_W-1:0]  stage_x,
  input  wire pos_flags_t        stage_pos,
  input  wire logic [ERR_W-1:0]  ram_rdata,
  input  wire logic [PIX_W-1:0]  threshold,
  output logic                   fire,
  output logic                   wr_en,
  output logic      [COL_W-1:0]  wr_addr,
  output logic      [ERR_W-1:0]  wr_data,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output logic      [PIX_W-1:0]  pixel_out,
  output logic                   row_end,
  output logic                   frame_end
);

  // carry: share for the next pixel in the row.
  // p_part: partial sum for the next-row entry under the last pixel.
  // q_part: partial sum for the entry one step further along.
  logic signed [ERR_W-1:0] carry, p_part, q_part;

  logic signed [ERR_W-1:0]  below_err, err, s7, s5, s3, s1, q_base;
  logic signed [ACC_W-1:0]  acc;
  logic signed [PROD_W-1:0] e, p7, p5, p3;
  logic        [PIX_W-1:0]  adj;
  logic                     out_hi;

  assign fire = stage_valid && (!result_valid || result_ready);

  always_comb begin
    if (stage_pos.row0) begin
      below_err = '0;
    end else if (stage_pos.first) begin
      // last entry of the previous row never went to the store
      below_err = p_part;
    end else begin
      below_err = $signed(ram_rdata);
    end

    acc = $signed(ACC_W'(stage_pixel)) + ACC_W'(below_err) + ACC_W'(carry);
    if (acc < 0) begin
      adj = PIX_BLACK;
    end else if (acc > ACC_W'(PIX_MAX)) begin
      adj = PIX_WHITE;
    end else begin
      adj = acc[PIX_W-1:0];
    end
    out_hi = (adj >= threshold);
    err    = $signed(ERR_W'(adj) - (out_hi ? ERR_W'(PIX_MAX) : ERR_W'(0)));

    e  = PROD_W'(err);
    p7 = (e <<< 3) - e;
    p5 = (e <<< 2) + e;
    p3 = (e <<< 1) + e;
    // floor(w*err/16): arithmetic shift, keep the upper bits
    s7 = $signed(p7[PROD_W-1:SHARE_SHIFT]);
    s5 = $signed(p5[PROD_W-1:SHARE_SHIFT]);
    s3 = $signed(p3[PROD_W-1:SHARE_SHIFT]);
    s1 = $signed(e[PROD_W-1:SHARE_SHIFT]);

    q_base = stage_pos.first ? '0 : q_part;

    // entry behind this pixel is complete once its 3/16 share lands
    wr_en   = fire && !stage_pos.first;
    wr_addr = stage_pos.l2r ? (stage_x - COL_W'(1)) : (stage_x + COL_W'(1));
    wr_data = p_part + s3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry  <= '0;
      p_part <= '0;
      q_part <= '0;
    end else if (fire) begin
      carry  <= stage_pos.row_end ? '0 : s7;
      p_part <= q_base + s5;
      q_part <= s1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pixel_out <= out_hi ? PIX_WHITE : PIX_BLACK;
      row_end   <= stage_pos.row_end;
      frame_end <= stage_pos.frame_end;
    end
  end

  `SEDH_ASSERT(a_carry_clear, clk, rst, (fire && stage_pos.row_end) |=> (carry == '0),
               "carry not cleared after row end")
  `SEDH_ASSERT(a_fire_result, clk, rst, fire |=> result_valid,
               "transaction fired but no result")
  `SEDH_ASSERT(a_frame_is_row_end, clk, rst, (result_valid && frame_end) |-> row_end,
               "frame end without row end")

endmodule

`default_nettype wire
